// ----- rtl/multicart_bank_mapper_with_irq_macros.svh -----
// Assertion helpers for the bank mapper; compiled out when SYNTH is set.
`ifndef MULTICART_BANK_MAPPER_WITH_IRQ_MACROS_SVH
`define MULTICART_BANK_MAPPER_WITH_IRQ_MACROS_SVH

`ifndef SYNTH
// Check a property on clk, held off while rst_n is low.
`define MCBM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property on clk at every edge, reset included.
`define MCBM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MCBM_ASSERT(lbl, prop, msg)
`define MCBM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/mcbm_pkg.sv -----
package mcbm_pkg;

  localparam int ADDR_W  = 16;
  localparam int DATA_W  = 8;
  localparam int DIP_W   = 5;
  localparam int BANK_W  = 3;
  localparam int PRG_W   = 6;
  localparam int CNT_W   = 12;

  localparam logic [ADDR_W-1:0] LO_MASK   = 16'h71FF;
  localparam logic [ADDR_W-1:0] HI_MASK   = 16'hF1FF;
  localparam logic [ADDR_W-1:0] DISK_ADDR = 16'h4022;
  localparam logic [ADDR_W-1:0] SWAP_ADDR = 16'h4120;
  localparam logic [ADDR_W-1:0] IRQ_ADDR  = 16'h4122;
  localparam logic [3:0]        APU_PAGE  = 4'h4;
  localparam logic [DIP_W-1:0]  DIP_HMIRROR = 5'h18;
  localparam logic [BANK_W-1:0] DISK_BANK_RST = 3'd3;

  typedef enum logic [1:0] {
    REQ_WRITE    = 2'd0,
    REQ_TICK     = 2'd1,
    REQ_XLAT     = 2'd2,
    REQ_SOFT_RST = 2'd3
  } req_t;

  // Mapper state seen by the translate logic and the checks.
  typedef struct packed {
    logic [BANK_W-1:0] disk_bank;
    logic [BANK_W-1:0] unrom_bank;
    logic              swap_mode;
    logic              irq_enable;
    logic              irq_line;
  } map_state_t;

  // Disk-game window at 0xC000, indexed by swap bit and disk bank.
  function automatic logic [PRG_W-1:0] disk_xlat(input logic sw,
                                                 input logic [BANK_W-1:0] bank);
    logic [3:0] v;
    if (!sw) begin
      unique case (bank)
        3'd0: v = 4'd4;
        3'd2: v = 4'd5;
        3'd4: v = 4'd6;
        3'd6: v = 4'd7;
        default: v = 4'd3;
      endcase
    end else begin
      unique case (bank)
        3'd2: v = 4'd5;
        3'd4: v = 4'd4;
        3'd6: v = 4'd5;
        default: v = 4'd1;
      endcase
    end
    return {2'b00, v};
  endfunction

endpackage

// ----- rtl/mcbm_if.sv -----
interface mcbm_req_if;
  import mcbm_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [ADDR_W-1:0] cpu_address;
  logic [DATA_W-1:0] write_data;
  modport source(output valid, req_type, cpu_address, write_data, input ready);
  modport sink(input valid, req_type, cpu_address, write_data, output ready);
endinterface

interface mcbm_res_if;
  import mcbm_pkg::*;
  logic             valid;
  logic             ready;
  logic [PRG_W-1:0] prg_bank;
  logic             prg_mapped;
  logic             irq_active;
  logic             mirror_horizontal;
  logic             apu_forward;
  modport source(output valid, prg_bank, prg_mapped, irq_active, mirror_horizontal,
                 apu_forward, input ready);
  modport sink(input valid, prg_bank, prg_mapped, irq_active, mirror_horizontal,
               apu_forward, output ready);
endinterface

interface mcbm_cfg_if;
  import mcbm_pkg::*;
  logic             valid;
  logic             ready;
  logic [DIP_W-1:0] dip_setting;
  modport source(output valid, dip_setting, input ready);
  modport sink(input valid, dip_setting, output ready);
endinterface

// ----- rtl/mcbm_state.sv -----
module mcbm_state (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step_en,
  input  logic [1:0]                  req_type,
  input  logic [mcbm_pkg::ADDR_W-1:0] cpu_address,
  input  logic [mcbm_pkg::DATA_W-1:0] write_data,
  output mcbm_pkg::map_state_t        cur,
  output logic                        irq_nxt,
  output logic                        apu_hit
);
  import mcbm_pkg::*;

  map_state_t       st_r, st_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [3:0]       page;
  req_t             req;

  assign req     = req_t'(req_type);
  assign page    = cpu_address[ADDR_W-1 -: 4];
  assign cnt_inc = cnt_r + 1'b1;

  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    apu_hit = 1'b0;
    unique case (req)
      REQ_WRITE: begin
        if (page >= APU_PAGE) begin
          if (page == APU_PAGE) begin
            apu_hit = 1'b1;
          end else if (cpu_address[ADDR_W-1]) begin
            st_nxt.unrom_bank = write_data[BANK_W-1:0];
          end
          if ((cpu_address & LO_MASK) == DISK_ADDR) begin
            st_nxt.disk_bank = write_data[BANK_W-1:0];
          end
          if ((cpu_address & LO_MASK) == SWAP_ADDR) begin
            st_nxt.swap_mode = write_data[0];
          end
          if ((cpu_address & HI_MASK) == IRQ_ADDR) begin
            st_nxt.irq_enable = write_data[0];
            st_nxt.irq_line   = 1'b0;
            cnt_nxt           = '0;
          end
        end
      end
      REQ_TICK: begin
        if (st_r.irq_enable) begin
          cnt_nxt = cnt_inc;
          if (cnt_inc == '0) begin
            st_nxt.irq_line = 1'b1;
          end
        end
      end
      REQ_XLAT: begin
      end
      REQ_SOFT_RST: begin
        st_nxt.irq_enable = 1'b0;
        cnt_nxt           = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.disk_bank  <= DISK_BANK_RST;
      st_r.unrom_bank <= '0;
      st_r.swap_mode  <= 1'b0;
      st_r.irq_enable <= 1'b0;
      st_r.irq_line   <= 1'b0;
      cnt_r           <= '0;
    end else if (step_en) begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign cur     = st_r;
  assign irq_nxt = st_nxt.irq_line;

endmodule

// ----- rtl/mcbm_xlat.sv -----
module mcbm_xlat (
  input  logic [1:0]                  req_type,
  input  logic [mcbm_pkg::ADDR_W-1:0] cpu_address,
  input  logic [mcbm_pkg::DIP_W-1:0]  dip_setting,
  input  mcbm_pkg::map_state_t        cur,
  output logic [mcbm_pkg::PRG_W-1:0]  prg_bank,
  output logic                        prg_mapped
);
  import mcbm_pkg::*;

  logic [2:0]       win;
  logic [DIP_W-1:0] b16;
  logic [PRG_W-1:0] b;
  logic             ok;
  logic             is_xlat;

  assign win     = cpu_address[ADDR_W-1 -: 3];
  assign is_xlat = (req_t'(req_type) == REQ_XLAT);

  always_comb begin
    b   = '0;
    ok  = 1'b1;
    b16 = cpu_address[ADDR_W-2] ? (dip_setting | DIP_W'(7))
                                : (dip_setting | DIP_W'(cur.unrom_bank));
    if (dip_setting == '0) begin
      unique case (win)
        3'd3: b = cur.swap_mode ? PRG_W'(0) : PRG_W'(2);
        3'd4: b = cur.swap_mode ? PRG_W'(0) : PRG_W'(1);
        3'd5: b = '0;
        3'd6: b = disk_xlat(cur.swap_mode, cur.disk_bank);
        3'd7: b = cur.swap_mode ? PRG_W'(8) : PRG_W'(10);
        default: ok = 1'b0;
      endcase
    end else if (cpu_address[ADDR_W-1]) begin
      b = {b16, cpu_address[ADDR_W-3]};
    end else begin
      ok = 1'b0;
    end
    if (is_xlat && ok) begin
      prg_bank   = b;
      prg_mapped = 1'b1;
    end else begin
      prg_bank   = '0;
      prg_mapped = 1'b0;
    end
  end

endmodule

// ----- rtl/multicart_bank_mapper_with_irq.sv -----
// Channel   Dir  Transaction
// in_req    in   one request: req_type, cpu_address, write_data
// out_res   out  one result: prg_bank, prg_mapped, irq_active, mirror, apu
// cfg_wr    in   dip_setting write, always ready
//
// One result per request; one request per cycle sustained while the output
// does not stall. A request sits in the input stage, where the mapper state
// updates and the translate logic works, and then moves into the output register.
// Reset (rst_n, synchronous, active low) empties both stages and loads the
// power-on mapper state. An output stall holds the output register; the input
// stage still takes a new request whenever it can move into that register.
`include "multicart_bank_mapper_with_irq_macros.svh"

module multicart_bank_mapper_with_irq (
  input  logic       clk,
  input  logic       rst_n,
  mcbm_req_if.sink   in_req,
  mcbm_res_if.source out_res,
  mcbm_cfg_if.sink   cfg_wr
);
  import mcbm_pkg::*;

  // Input stage: the request being worked on.
  logic              stg_v_r;
  logic [1:0]        stg_type_r;
  logic [ADDR_W-1:0] stg_addr_r;
  logic [DATA_W-1:0] stg_data_r;

  // Output register.
  logic              out_v_r;
  logic [PRG_W-1:0]  out_bank_r;
  logic              out_mapped_r;
  logic              out_irq_r;
  logic              out_mirror_r;
  logic              out_apu_r;

  logic [DIP_W-1:0]  dip_r;

  logic              advance;
  logic              in_fire;
  map_state_t        cur;
  logic              irq_nxt;
  logic              apu_hit;
  logic [PRG_W-1:0]  xl_bank;
  logic              xl_mapped;

  // Advance the stage when the output register is empty or being drained.
  assign advance      = stg_v_r && (!out_v_r || out_res.ready);
  assign in_req.ready = !stg_v_r || advance;
  assign in_fire      = in_req.valid && in_req.ready;
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (in_req.ready) begin
      stg_v_r <= in_req.valid;
    end
  end

  // Payload loads only on a transaction; no reset needed.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_type_r <= in_req.req_type;
      stg_addr_r <= in_req.cpu_address;
      stg_data_r <= in_req.write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dip_r <= '0;
    end else if (cfg_wr.valid) begin
      dip_r <= cfg_wr.dip_setting;
    end
  end

  mcbm_state u_state (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (advance),
    .req_type    (stg_type_r),
    .cpu_address (stg_addr_r),
    .write_data  (stg_data_r),
    .cur         (cur),
    .irq_nxt     (irq_nxt),
    .apu_hit     (apu_hit)
  );

  mcbm_xlat u_xlat (
    .req_type    (stg_type_r),
    .cpu_address (stg_addr_r),
    .dip_setting (dip_r),
    .cur         (cur),
    .prg_bank    (xl_bank),
    .prg_mapped  (xl_mapped)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_res.ready) begin
      out_v_r <= 1'b0;
    end
  end

  // Hold the result until it is taken; load the next one on advance.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_bank_r   <= xl_bank;
      out_mapped_r <= xl_mapped;
      out_irq_r    <= irq_nxt;
      out_mirror_r <= (dip_r == DIP_HMIRROR);
      out_apu_r    <= apu_hit;
    end
  end

  assign out_res.valid             = out_v_r;
  assign out_res.prg_bank          = out_bank_r;
  assign out_res.prg_mapped        = out_mapped_r;
  assign out_res.irq_active        = out_irq_r;
  assign out_res.mirror_horizontal = out_mirror_r;
  assign out_res.apu_forward       = out_apu_r;

  // The input side stalls only when both stages are full and the sink waits.
  `MCBM_ASSERT(a_stall_cause, !in_req.ready |-> (stg_v_r && out_v_r && !out_res.ready), "input stalled without a full pipe")
  // The IRQ line rises only from a counted cycle tick.
  `MCBM_ASSERT(a_irq_rise, $rose(cur.irq_line) |-> $past(advance && (req_t'(stg_type_r) == REQ_TICK)), "irq rose without a tick")
  // An acknowledge write drops the IRQ line.
  `MCBM_ASSERT(a_irq_ack, (advance && (req_t'(stg_type_r) == REQ_WRITE) && ((stg_addr_r & HI_MASK) == IRQ_ADDR)) |=> !cur.irq_line, "irq ack missed")
  // Only translate requests report a mapped window.
  `MCBM_ASSERT(a_map_xlat, (stg_v_r && xl_mapped) |-> (req_t'(stg_type_r) == REQ_XLAT), "mapped flag on a non-translate request")

endmodule
